@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files of the ALU project.
// No dependencies; each macro samples on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked assertion.
`define CAF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Clocked assertion that is switched off while rst is high.
`define CAF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

@@ rtl/caf_pkg.sv @@
// Package for the CPU ALU with flags: operation codes, flag positions and the
// structs passed between the top level and its compute units. No dependencies.
package caf_pkg;

  localparam int OpW = 5;

  localparam logic [OpW-1:0] OP_INC8  = 5'd0;
  localparam logic [OpW-1:0] OP_DEC8  = 5'd1;
  localparam logic [OpW-1:0] OP_SCF   = 5'd2;
  localparam logic [OpW-1:0] OP_CCF   = 5'd3;
  localparam logic [OpW-1:0] OP_CPL   = 5'd4;
  localparam logic [OpW-1:0] OP_DAA   = 5'd5;
  localparam logic [OpW-1:0] OP_ADDHL = 5'd6;
  localparam logic [OpW-1:0] OP_SPE8  = 5'd7;
  localparam logic [OpW-1:0] OP_ADD   = 5'd8;
  localparam logic [OpW-1:0] OP_ADC   = 5'd9;
  localparam logic [OpW-1:0] OP_SUB   = 5'd10;
  localparam logic [OpW-1:0] OP_SBC   = 5'd11;
  localparam logic [OpW-1:0] OP_AND   = 5'd12;
  localparam logic [OpW-1:0] OP_XOR   = 5'd13;
  localparam logic [OpW-1:0] OP_OR    = 5'd14;
  localparam logic [OpW-1:0] OP_CP    = 5'd15;
  localparam logic [OpW-1:0] OP_RLC   = 5'd16;
  localparam logic [OpW-1:0] OP_RRC   = 5'd17;
  localparam logic [OpW-1:0] OP_RL    = 5'd18;
  localparam logic [OpW-1:0] OP_RR    = 5'd19;
  localparam logic [OpW-1:0] OP_SLA   = 5'd20;
  localparam logic [OpW-1:0] OP_SRA   = 5'd21;
  localparam logic [OpW-1:0] OP_SWAP  = 5'd22;
  localparam logic [OpW-1:0] OP_SRL   = 5'd23;
  localparam logic [OpW-1:0] OP_BIT   = 5'd24;
  localparam logic [OpW-1:0] OP_RES   = 5'd25;
  localparam logic [OpW-1:0] OP_SET   = 5'd26;
  localparam logic [OpW-1:0] OP_INC16 = 5'd27;
  localparam logic [OpW-1:0] OP_DEC16 = 5'd28;

  // Flag bit positions within the 4-bit flag word.
  localparam int FlagZ = 3;
  localparam int FlagN = 2;
  localparam int FlagH = 1;
  localparam int FlagC = 0;

  localparam logic [7:0] DaaLimit   = 8'h99;
  localparam logic [7:0] DaaHiAdj   = 8'h60;
  localparam logic [7:0] DaaLoAdj   = 8'h06;
  localparam logic [3:0] DaaLoLimit = 4'h9;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [7:0]        a_in;
    logic [3:0]        flags_in;
    logic [7:0]        operand_byte;
    logic [2:0]        bit_index;
    logic [15:0]       hl_in;
    logic [15:0]       sp_in;
    logic [15:0]       operand_word;
    logic signed [7:0] offset;
  } caf_item_t;

  typedef struct packed {
    logic [7:0] a_out;
    logic [7:0] res8;
    logic [3:0] flags;
  } caf_byte_res_t;

  typedef struct packed {
    logic [15:0] res16;
    logic [3:0]  flags;
    logic        flags_valid;
  } caf_word_res_t;

endpackage

@@ rtl/caf_byte_unit.sv @@
// 8-bit datapath of the CPU ALU: accumulator arithmetic, logic, DAA, rotates,
// shifts, swap and bit operations with their flags. Depends on caf_pkg.
module caf_byte_unit (
  input  caf_pkg::caf_item_t     item,
  output caf_pkg::caf_byte_res_t res
);
  import caf_pkg::*;

  logic [7:0] a;
  logic [7:0] d;
  logic [3:0] f;
  logic       cy;
  logic       cs;
  logic [8:0] sum9;
  logic [4:0] half5;
  logic [8:0] diff9;
  logic [4:0] hdiff5;
  logic [7:0] r8;
  logic [7:0] bit_mask;
  logic       daa_lo;
  logic       daa_hi;
  logic [7:0] daa_add;
  logic [7:0] daa_sub;
  logic [7:0] daa_a;
  logic       daa_c;
  logic       sh_c;

  assign a = item.a_in;
  assign d = item.operand_byte;
  assign f = item.flags_in;

  assign cy     = (item.op == OP_ADC) ? f[FlagC] : 1'b0;
  assign cs     = (item.op == OP_SBC) ? f[FlagC] : 1'b0;
  assign sum9   = {1'b0, a} + {1'b0, d} + {8'b0, cy};
  assign half5  = {1'b0, a[3:0]} + {1'b0, d[3:0]} + {4'b0, cy};
  assign diff9  = {1'b0, a} - {1'b0, d} - {8'b0, cs};
  assign hdiff5 = {1'b0, a[3:0]} - {1'b0, d[3:0]} - {4'b0, cs};

  assign bit_mask = 8'd1 << item.bit_index;

  // Decimal adjust: both corrections are decided from the incoming value.
  assign daa_lo  = f[FlagH] | (a[3:0] > DaaLoLimit);
  assign daa_hi  = f[FlagC] | (a > DaaLimit);
  assign daa_add = a + (daa_hi ? DaaHiAdj : 8'd0) + (daa_lo ? DaaLoAdj : 8'd0);
  assign daa_sub = a - (f[FlagC] ? DaaHiAdj : 8'd0) - (f[FlagH] ? DaaLoAdj : 8'd0);
  assign daa_a   = f[FlagN] ? daa_sub : daa_add;
  assign daa_c   = f[FlagN] ? f[FlagC] : daa_hi;

  always_comb begin
    r8   = 8'd0;
    sh_c = 1'b0;
    case (item.op)
      OP_RLC: begin
        r8 = {d[6:0], d[7]};
        sh_c = d[7];
      end
      OP_RRC: begin
        r8 = {d[0], d[7:1]};
        sh_c = d[0];
      end
      OP_RL: begin
        r8 = {d[6:0], f[FlagC]};
        sh_c = d[7];
      end
      OP_RR: begin
        r8 = {f[FlagC], d[7:1]};
        sh_c = d[0];
      end
      OP_SLA: begin
        r8 = {d[6:0], 1'b0};
        sh_c = d[7];
      end
      OP_SRA: begin
        r8 = {d[7], d[7:1]};
        sh_c = d[0];
      end
      OP_SWAP: begin
        r8 = {d[3:0], d[7:4]};
      end
      OP_SRL: begin
        r8 = {1'b0, d[7:1]};
        sh_c = d[0];
      end
      default: begin
        r8 = 8'd0;
      end
    endcase
  end

  always_comb begin
    res.a_out = a;
    res.res8  = 8'd0;
    res.flags = f;
    case (item.op)
      OP_INC8: begin
        res.res8  = d + 8'd1;
        res.flags = {(d == 8'hff), 1'b0, (d[3:0] == 4'hf), f[FlagC]};
      end
      OP_DEC8: begin
        res.res8  = d - 8'd1;
        res.flags = {(d == 8'h01), 1'b1, (d[3:0] == 4'h0), f[FlagC]};
      end
      OP_SCF: res.flags = {f[FlagZ], 1'b0, 1'b0, 1'b1};
      OP_CCF: res.flags = {f[FlagZ], 1'b0, 1'b0, ~f[FlagC]};
      OP_CPL: begin
        res.a_out = ~a;
        res.flags = {f[FlagZ], 1'b1, 1'b1, f[FlagC]};
      end
      OP_DAA: begin
        res.a_out = daa_a;
        res.flags = {(daa_a == 8'd0), f[FlagN], 1'b0, daa_c};
      end
      OP_ADD, OP_ADC: begin
        res.a_out = sum9[7:0];
        res.flags = {(sum9[7:0] == 8'd0), 1'b0, half5[4], sum9[8]};
      end
      OP_SUB, OP_SBC: begin
        res.a_out = diff9[7:0];
        res.flags = {(diff9[7:0] == 8'd0), 1'b1, hdiff5[4], diff9[8]};
      end
      OP_CP: begin
        res.flags = {(diff9[7:0] == 8'd0), 1'b1, hdiff5[4], diff9[8]};
      end
      OP_AND: begin
        res.a_out = a & d;
        res.flags = {((a & d) == 8'd0), 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        res.a_out = a ^ d;
        res.flags = {((a ^ d) == 8'd0), 1'b0, 1'b0, 1'b0};
      end
      OP_OR: begin
        res.a_out = a | d;
        res.flags = {((a | d) == 8'd0), 1'b0, 1'b0, 1'b0};
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
        res.res8  = r8;
        res.flags = {(r8 == 8'd0), 1'b0, 1'b0, sh_c};
      end
      OP_BIT: res.flags = {((d & bit_mask) == 8'd0), 1'b0, 1'b1, f[FlagC]};
      OP_RES: res.res8 = d & ~bit_mask;
      OP_SET: res.res8 = d | bit_mask;
      default: begin
        res.a_out = a;
      end
    endcase
  end

endmodule

@@ rtl/caf_word_unit.sv @@
// 16-bit datapath of the CPU ALU: add HL, SP plus signed offset, and 16-bit
// increment and decrement. Depends on caf_pkg.
module caf_word_unit (
  input  caf_pkg::caf_item_t     item,
  output caf_pkg::caf_word_res_t res
);
  import caf_pkg::*;

  logic [16:0] hl_sum;
  logic [12:0] hl_half;
  logic [15:0] sp_sum;
  logic [4:0]  sp_half;
  logic [8:0]  sp_low;
  logic [3:0]  f;

  assign f       = item.flags_in;
  assign hl_sum  = {1'b0, item.hl_in} + {1'b0, item.operand_word};
  assign hl_half = {1'b0, item.hl_in[11:0]} + {1'b0, item.operand_word[11:0]};
  assign sp_sum  = item.sp_in + {{8{item.offset[7]}}, item.offset};
  // H and C for SP plus offset come from the unsigned low-byte sum.
  assign sp_half = {1'b0, item.sp_in[3:0]} + {1'b0, item.offset[3:0]};
  assign sp_low  = {1'b0, item.sp_in[7:0]} + {1'b0, item.offset[7:0]};

  always_comb begin
    res.res16       = 16'd0;
    res.flags       = f;
    res.flags_valid = 1'b0;
    case (item.op)
      OP_ADDHL: begin
        res.res16       = hl_sum[15:0];
        res.flags       = {f[FlagZ], 1'b0, hl_half[12], hl_sum[16]};
        res.flags_valid = 1'b1;
      end
      OP_SPE8: begin
        res.res16       = sp_sum;
        res.flags       = {1'b0, 1'b0, sp_half[4], sp_low[8]};
        res.flags_valid = 1'b1;
      end
      OP_INC16: res.res16 = item.operand_word + 16'd1;
      OP_DEC16: res.res16 = item.operand_word - 16'd1;
      default: begin
        res.res16 = 16'd0;
      end
    endcase
  end

endmodule

@@ rtl/cpu_alu_with_flags_unit.sv @@
// Top level of the 8-bit CPU ALU with Z/N/H/C flags: input register, byte and
// word compute units, result register. Depends on caf_pkg, caf_byte_unit, caf_word_unit.
//
// Usage:
//   An operation is transferred in at a rising edge of clk where start is high and
//   busy is low. busy is held low: the unit takes a new operation in every cycle.
//   The operation and all of its operands are captured in an input register, the
//   byte and word units evaluate it combinationally, and the outcome is captured in
//   the result register.
//   An operation transferred at an edge passes the input register and then the result
//   register; its result shows on a_out, byte_result, flags_out and word_result, with
//   done high, for a single cycle, and is transferred at the edge that ends that cycle.
//   Throughput is one operation per cycle, set by the single register stage on
//   each side of the compute logic.
//   The receiver cannot hold results off; each result is transferred at the edge
//   that ends its done cycle, so no result storage beyond the output register is
//   needed.
//   Flags that an operation does not define pass through from flags_in. Unused
//   opcodes return the accumulator and flags unchanged with zero results.
//   A synchronous reset on rst clears the valid bits of both stages, so nothing
//   in flight at reset comes out as a result.
module cpu_alu_with_flags_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [4:0]        op,
  input  logic [7:0]        a_in,
  input  logic [3:0]        flags_in,
  input  logic [7:0]        operand_byte,
  input  logic [2:0]        bit_index,
  input  logic [15:0]       hl_in,
  input  logic [15:0]       sp_in,
  input  logic [15:0]       operand_word,
  input  logic signed [7:0] offset,
  output logic              done,
  output logic [7:0]        a_out,
  output logic [7:0]        byte_result,
  output logic [3:0]        flags_out,
  output logic [15:0]       word_result
);
  import caf_pkg::*;

  caf_item_t     item;
  logic          item_valid;
  caf_byte_res_t bres;
  caf_word_res_t wres;

  // The pipeline never stalls, so the unit is never busy.
  assign busy = 1'b0;

  // Input register: the payload needs no reset, only its valid bit does.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      item.op           <= op;
      item.a_in         <= a_in;
      item.flags_in     <= flags_in;
      item.operand_byte <= operand_byte;
      item.bit_index    <= bit_index;
      item.hl_in        <= hl_in;
      item.sp_in        <= sp_in;
      item.operand_word <= operand_word;
      item.offset       <= offset;
    end
  end

  caf_byte_unit u_byte (
    .item (item),
    .res  (bres)
  );

  caf_word_unit u_word (
    .item (item),
    .res  (wres)
  );

  // Result register. The word unit owns the flags for add HL and SP plus
  // offset; for every other operation the byte unit's flags are used.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      a_out       <= bres.a_out;
      byte_result <= bres.res8;
      flags_out   <= wres.flags_valid ? wres.flags : bres.flags;
      word_result <= wres.res16;
    end
  end

endmodule

@@ rtl/caf_checker.sv @@
// Port-level checker for cpu_alu_with_flags_unit and the bind that attaches it.
// Depends on caf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module caf_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [4:0]  op,
  input logic [7:0]  a_in,
  input logic [15:0] operand_word,
  input logic        done,
  input logic [7:0]  a_out,
  input logic [15:0] word_result
);
  import caf_pkg::*;

  `CAF_ASSERT(a_never_busy, !busy, "busy went high")
  `CAF_ASSERT(a_no_done_after_rst, $past(rst) |-> !done, "done right after reset")
  `CAF_ASSERT_RST(a_latency,
    (!$past(rst) && !$past(rst, 2)) |-> (done == $past(start, 2)),
    "done does not follow start by two cycles")
  `CAF_ASSERT_RST(a_cpl,
    (done && $past(op, 2) == OP_CPL) |-> (a_out == ~$past(a_in, 2)),
    "cpl result wrong")
  `CAF_ASSERT_RST(a_inc16,
    (done && $past(op, 2) == OP_INC16) |-> (word_result == $past(operand_word, 2) + 16'd1),
    "inc16 result wrong")

endmodule

bind cpu_alu_with_flags_unit caf_checker u_caf_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .op           (op),
  .a_in         (a_in),
  .operand_word (operand_word),
  .done         (done),
  .a_out        (a_out),
  .word_result  (word_result)
);

@@ dv/cpu_alu_with_flags_unit_tb.sv @@
// Self-checking testbench for cpu_alu_with_flags_unit: directed corner operations, then
// random ones, each checked against an in-bench ALU predictor. Depends on caf_pkg and the RTL.
module cpu_alu_with_flags_unit_tb;
  import caf_pkg::*;

  // Generous cycle limit.
  localparam int CycleLimit = 200000;
  localparam int RandomOps  = 1400;

  // One expected outcome of the ALU, at the widths of the result ports.
  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  byte_val;
    logic [3:0]  flags;
    logic [15:0] word_val;
  } alu_outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  logic [7:0]  a_out;
  logic [7:0]  byte_result;
  logic [3:0]  flags_out;
  logic [15:0] word_result;

  // The operation on the input ports. Every input field comes from this one struct,
  // so all of them are known from time zero.
  caf_item_t cur_item = '0;

  caf_item_t    pending_ops[$];
  alu_outcome_t alu_results_due[$];

  int  total_ops      = 0;
  int  ops_accepted   = 0;
  int  mismatch_count = 0;
  int  cycle_count    = 0;
  logic taken = 1'b0;

  cpu_alu_with_flags_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (cur_item.op),
    .a_in         (cur_item.a_in),
    .flags_in     (cur_item.flags_in),
    .operand_byte (cur_item.operand_byte),
    .bit_index    (cur_item.bit_index),
    .hl_in        (cur_item.hl_in),
    .sp_in        (cur_item.sp_in),
    .operand_word (cur_item.operand_word),
    .offset       (cur_item.offset),
    .done         (done),
    .a_out        (a_out),
    .byte_result  (byte_result),
    .flags_out    (flags_out),
    .word_result  (word_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Computes what the ALU must return for one operation. The flag word is laid out
  // as {Z, N, H, C}; flags that an operation does not define keep their input value.
  function automatic alu_outcome_t alu_predict(caf_item_t it);
    logic [7:0]  acc;
    logic [7:0]  d;
    logic [7:0]  e;
    logic [7:0]  diff;
    logic [7:0]  byte_val;
    logic [15:0] word_val;
    logic [3:0]  f;
    logic [8:0]  sum9;
    logic [4:0]  nib5;
    logic [12:0] sum13;
    logic [16:0] sum17;
    logic        cin;
    logic        cc;
    logic        carry;
    logic        half;
    logic        low_fix;
    logic        shift_flags;
    alu_outcome_t res;
    acc         = it.a_in;
    d           = it.operand_byte;
    e           = it.offset;
    f           = it.flags_in;
    cin         = f[FlagC];
    byte_val    = '0;
    word_val    = '0;
    carry       = 1'b0;
    shift_flags = 1'b0;
    cc          = ((it.op == OP_ADC) || (it.op == OP_SBC)) ? cin : 1'b0;
    case (it.op)
      OP_INC8: begin
        byte_val = d + 8'd1;
        f = {byte_val == 8'h00, 1'b0, d[3:0] == 4'hf, cin};
      end
      OP_DEC8: begin
        byte_val = d - 8'd1;
        f = {byte_val == 8'h00, 1'b1, d[3:0] == 4'h0, cin};
      end
      OP_SCF: f = {f[FlagZ], 3'b001};
      OP_CCF: f = {f[FlagZ], 2'b00, ~cin};
      OP_CPL: begin
        acc = ~acc;
        f[FlagN] = 1'b1;
        f[FlagH] = 1'b1;
      end
      OP_DAA: begin
        // The decimal fixup depends on whether the last operation was a subtraction.
        // Both tests of the addition path look at the accumulator before any fixup.
        if (!f[FlagN]) begin
          carry   = cin;
          low_fix = f[FlagH] || (acc[3:0] > 4'h9);
          if (carry || (acc > 8'h99)) begin
            acc   = acc + 8'h60;
            carry = 1'b1;
          end
          if (low_fix) acc = acc + 8'h06;
          f[FlagC] = carry;
        end else begin
          if (cin) acc = acc - 8'h60;
          if (f[FlagH]) acc = acc - 8'h06;
        end
        f[FlagZ] = (acc == 8'h00);
        f[FlagH] = 1'b0;
      end
      OP_ADDHL: begin
        sum17    = it.hl_in + it.operand_word;
        sum13    = it.hl_in[11:0] + it.operand_word[11:0];
        word_val = sum17[15:0];
        f = {f[FlagZ], 1'b0, sum13[12], sum17[16]};
      end
      OP_SPE8: begin
        // The carries come from the unsigned low-byte sum, whatever the sign.
        word_val = it.sp_in + {{8{e[7]}}, e};
        nib5     = it.sp_in[3:0] + e[3:0];
        sum9     = it.sp_in[7:0] + e;
        f = {2'b00, nib5[4], sum9[8]};
      end
      OP_ADD, OP_ADC: begin
        sum9 = acc + d + cc;
        nib5 = acc[3:0] + d[3:0] + cc;
        f    = {sum9[7:0] == 8'h00, 1'b0, nib5[4], sum9[8]};
        acc  = sum9[7:0];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        diff  = acc - d - cc;
        half  = {1'b0, acc[3:0]} < ({1'b0, d[3:0]} + cc);
        carry = {1'b0, acc} < ({1'b0, d} + cc);
        f     = {diff == 8'h00, 1'b1, half, carry};
        if (it.op != OP_CP) acc = diff;
      end
      OP_AND: begin
        acc = acc & d;
        f   = {acc == 8'h00, 3'b010};
      end
      OP_XOR: begin
        acc = acc ^ d;
        f   = {acc == 8'h00, 3'b000};
      end
      OP_OR: begin
        acc = acc | d;
        f   = {acc == 8'h00, 3'b000};
      end
      OP_RLC: begin
        byte_val = {d[6:0], d[7]};
        carry = d[7];
        shift_flags = 1'b1;
      end
      OP_RRC: begin
        byte_val = {d[0], d[7:1]};
        carry = d[0];
        shift_flags = 1'b1;
      end
      OP_RL: begin
        byte_val = {d[6:0], cin};
        carry = d[7];
        shift_flags = 1'b1;
      end
      OP_RR: begin
        byte_val = {cin, d[7:1]};
        carry = d[0];
        shift_flags = 1'b1;
      end
      OP_SLA: begin
        byte_val = {d[6:0], 1'b0};
        carry = d[7];
        shift_flags = 1'b1;
      end
      OP_SRA: begin
        byte_val = {d[7], d[7:1]};
        carry = d[0];
        shift_flags = 1'b1;
      end
      OP_SWAP: begin
        byte_val = {d[3:0], d[7:4]};
        shift_flags = 1'b1;
      end
      OP_SRL: begin
        byte_val = {1'b0, d[7:1]};
        carry = d[0];
        shift_flags = 1'b1;
      end
      OP_BIT: f = {~d[it.bit_index], 2'b01, cin};
      OP_RES: begin
        byte_val = d;
        byte_val[it.bit_index] = 1'b0;
      end
      OP_SET: begin
        byte_val = d;
        byte_val[it.bit_index] = 1'b1;
      end
      OP_INC16: word_val = it.operand_word + 16'd1;
      OP_DEC16: word_val = it.operand_word - 16'd1;
      default: ;
    endcase
    if (shift_flags) f = {byte_val == 8'h00, 2'b00, carry};
    res.acc      = acc;
    res.byte_val = byte_val;
    res.flags    = f;
    res.word_val = word_val;
    return res;
  endfunction

  function automatic caf_item_t make_op(logic [4:0] op, logic [7:0] a, logic [3:0] f,
                                        logic [7:0] d, logic [2:0] bi, logic [15:0] hl,
                                        logic [15:0] sp, logic [15:0] w, logic [7:0] e);
    caf_item_t it;
    it.op           = op;
    it.a_in         = a;
    it.flags_in     = f;
    it.operand_byte = d;
    it.bit_index    = bi;
    it.hl_in        = hl;
    it.sp_in        = sp;
    it.operand_word = w;
    it.offset       = e;
    return it;
  endfunction

  // Random byte that lands on a boundary value about one time in eight.
  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    v = 8'($urandom_range(255));
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: v = 8'h00;
        1: v = 8'hff;
        2: v = 8'h0f;
        default: v = 8'h80;
      endcase
    end
    return v;
  endfunction

  function automatic logic [15:0] pick_word();
    logic [15:0] v;
    v = 16'($urandom_range(65535));
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: v = 16'h0000;
        1: v = 16'hffff;
        2: v = 16'h0fff;
        default: v = 16'h00ff;
      endcase
    end
    return v;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Driver. A new operation goes on the ports at the falling edge once the previous
  // one has been transferred. The share of idle cycles follows the phase of the run:
  // light idling first, heavy idling next, and back-to-back transfers at the end.
  always @(negedge clk) begin
    int idle_pct;
    if (ops_accepted < total_ops / 3) idle_pct = 15;
    else if (ops_accepted < (2 * total_ops) / 3) idle_pct = 62;
    else idle_pct = 0;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if ((pending_ops.size() != 0) && ($urandom_range(99) >= idle_pct)) begin
        cur_item <= pending_ops.pop_front();
        start    <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. Results are checked before the expectation of a transfer at the same edge
  // is queued; the input and result registers lie between, so it never belongs to that transfer.
  always @(posedge clk) begin
    alu_outcome_t want;
    cycle_count <= cycle_count + 1;
    taken <= !rst && start && !busy;
    if (!rst) begin
      if (done) begin
        if (alu_results_due.size() == 0) begin
          $display("%0t: result with no operation outstanding: a %h byte %h flags %h word %h",
                   $time, a_out, byte_result, flags_out, word_result);
          mismatch_count++;
        end else begin
          want = alu_results_due.pop_front();
          check_field("a_out", 16'(want.acc), 16'(a_out));
          check_field("byte_result", 16'(want.byte_val), 16'(byte_result));
          check_field("flags_out", 16'(want.flags), 16'(flags_out));
          check_field("word_result", want.word_val, word_result);
        end
      end
      if (start && !busy) begin
        alu_results_due.push_back(alu_predict(cur_item));
        ops_accepted++;
      end
    end
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    caf_item_t it;
    logic [7:0] ones;
    int pick;

    // Directed part: every opcode, including an unused one, with all fields at zero or
    // all at their maximum, so rl and rr see both carry values. Then decimal adjust on
    // both of its paths, and a stack pointer offset whose unsigned low-byte sum carries out.
    for (int o = 0; o < 32; o++) begin
      if ((o == 29) || (o == 30)) continue;
      ones = (o % 2 == 0) ? 8'hff : 8'h00;
      pending_ops.push_back(make_op(5'(o), ones, ones[3:0], ones, ones[2:0],
                                    {ones, ones}, {ones, ones}, {ones, ones}, ones));
    end
    pending_ops.push_back(make_op(OP_DAA, 8'h9a, 4'b0000, 8'h00, 3'd0, '0, '0, '0, 8'h00));
    pending_ops.push_back(make_op(OP_DAA, 8'h00, 4'b0111, 8'h00, 3'd0, '0, '0, '0, 8'h00));
    pending_ops.push_back(make_op(OP_SPE8, 8'h00, 4'b1111, 8'h00, 3'd0, '0, 16'h00ff, '0,
                                  8'h80));

    // Random part. A few operations use the unused opcodes, which must change nothing.
    for (int i = 0; i < RandomOps; i++) begin
      pick = $urandom_range(99);
      it.op           = (pick < 4) ? 5'($urandom_range(31, 29)) : 5'($urandom_range(28));
      it.a_in         = pick_byte();
      it.flags_in     = 4'($urandom_range(15));
      it.operand_byte = pick_byte();
      it.bit_index    = 3'($urandom_range(7));
      it.hl_in        = pick_word();
      it.sp_in        = pick_word();
      it.operand_word = pick_word();
      it.offset       = pick_byte();
      pending_ops.push_back(it);
    end
    total_ops = pending_ops.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (ops_accepted < total_ops) @(posedge clk);
    while (alu_results_due.size() != 0) @(posedge clk);
    // Waiting on past the last result catches any stray result strobe.
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
